FILE: hw/rtl/sem_pkg.sv
// Shared types, constants and arithmetic helpers for the Sobel edge magnitude core.
// No dependencies; every other file in hw/rtl refers to this package by scoped names.
package sem_pkg;

  // Field widths
  localparam int PIX_W        = 8;
  localparam int COL_W        = 11;
  localparam int ROW_W        = 16;
  localparam int WIDTH_REG_W  = 12;
  localparam int HEIGHT_REG_W = 16;
  localparam int CFG_W        = 16;
  localparam int CFG_INDEX_W  = 1;

  // Register indexes on the configuration port
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

  localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 12'd640;
  localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 16'd480;

  localparam int MAX_WIDTH_DEFAULT = 2048;
  localparam int QUEUE_DEPTH       = 4;

  // Result slots released by one pixel, in release order
  localparam int SLOT_UP_PREV  = 0;  // row above, previous column
  localparam int SLOT_UP_LAST  = 1;  // row above, last column
  localparam int SLOT_CUR_PREV = 2;  // last row, previous column
  localparam int SLOT_CUR_LAST = 3;  // last row, last column
  localparam int NUM_SLOTS     = 4;

  // Window positions (row or column within the 3x3 window)
  localparam logic [1:0] POS_OLD = 2'd0;
  localparam logic [1:0] POS_MID = 2'd1;
  localparam logic [1:0] POS_NEW = 2'd2;

  // floor(x/3) for x <= 765 as (x * 683) >> 11
  localparam logic [19:0] GRAY_RECIP = 20'd683;

  // [row*3+col]; rows oldest..newest, columns oldest..newest
  typedef logic [8:0][PIX_W-1:0] window_t;

  typedef struct packed {
    logic col_ge1;
    logic col_ge2;
    logic row_ge1;
    logic row_ge2;
  } border_t;

  typedef struct packed {
    window_t               window;
    logic [COL_W-1:0]      col;
    logic [ROW_W-1:0]      row;
    border_t               border;
    logic [NUM_SLOTS-1:0]  slots;
  } q_entry_t;

  function automatic logic [PIX_W-1:0] gray_of(input logic [PIX_W-1:0] r,
                                               input logic [PIX_W-1:0] g,
                                               input logic [PIX_W-1:0] b);
    logic [9:0]  sum;
    logic [19:0] prod;
    sum  = 10'(r) + 10'(g) + 10'(b);
    prod = 20'(sum) * GRAY_RECIP;
    return prod[18:11];
  endfunction

  function automatic logic [3:0] win_idx(input logic [1:0] row, input logic [1:0] col);
    return 4'(row) * 4'd3 + 4'(col);
  endfunction

  // Weighted 1-2-1 sum of three window pixels
  function automatic logic [9:0] tap3(input logic [PIX_W-1:0] a,
                                      input logic [PIX_W-1:0] m,
                                      input logic [PIX_W-1:0] c);
    return 10'(a) + (10'(m) << 1) + 10'(c);
  endfunction

  function automatic logic [9:0] abs_diff(input logic [9:0] a, input logic [9:0] b);
    logic [10:0] d;
    d = {1'b0, a} - {1'b0, b};
    return d[10] ? 10'(-d) : d[9:0];
  endfunction

  // |gx| + |gy| over the selected rows and columns, saturated to 8 bits
  function automatic logic [PIX_W-1:0] sobel_mag(input window_t w,
                                                 input logic [1:0] ct,
                                                 input logic [1:0] cm,
                                                 input logic [1:0] cr,
                                                 input logic [1:0] rt,
                                                 input logic [1:0] rm,
                                                 input logic [1:0] rb);
    logic [9:0]  right;
    logic [9:0]  left;
    logic [9:0]  bottom;
    logic [9:0]  top;
    logic [10:0] mag;
    right  = tap3(w[win_idx(rt, cr)], w[win_idx(rm, cr)], w[win_idx(rb, cr)]);
    left   = tap3(w[win_idx(rt, ct)], w[win_idx(rm, ct)], w[win_idx(rb, ct)]);
    bottom = tap3(w[win_idx(rb, ct)], w[win_idx(rb, cm)], w[win_idx(rb, cr)]);
    top    = tap3(w[win_idx(rt, ct)], w[win_idx(rt, cm)], w[win_idx(rt, cr)]);
    mag    = 11'(abs_diff(right, left)) + 11'(abs_diff(bottom, top));
    return (mag > 11'd255) ? 8'd255 : mag[7:0];
  endfunction

endpackage

FILE: hw/rtl/sobel_edge_magnitude_core.sv
// Top level of the streaming 3x3 Sobel edge magnitude core.
// Instantiates sem_front, sem_queue and sem_back; types and constants from sem_pkg.
//
// RGB pixels come in raster order, one per transfer, and are turned into gray as
// (r+g+b)/3; two line stores of MAX_WIDTH entries and a 3x3 window feed the Sobel kernels,
// with edge replication on every border. Each result carries its column and row and
// min(|gx|+|gy|, 255). Results trail the input by one row and one column; a pixel in the
// last column or last row also releases the results that became complete with it, so one
// input transfer releases zero to four result transfers, in order: row above (previous
// column, then this column on the last column), then the current row on the last row.
// last_of_run marks the final result of an input, frame_done the bottom-right pixel.
// Rate: the front end takes one pixel per clock while the queue has room; the back end
// emits one result per clock while the queue is not empty and the output is not stalled,
// and the four-entry queue between them absorbs the extra results at the right edge. The
// last row of a frame releases two results per pixel and so stalls the input once the
// queue is full. An input passes stage B, the queue and the output register. The user
// writes image_width (index 0, clamped to 1..MAX_WIDTH) and image_height (index 1, zero
// counts as one) on the config port only while the core is idle, not enforced by it.
module sobel_edge_magnitude_core #(
  parameter int MAX_WIDTH = sem_pkg::MAX_WIDTH_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write_enable,
  input  logic [sem_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [sem_pkg::CFG_W-1:0]         cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [sem_pkg::PIX_W-1:0]         red,
  input  logic [sem_pkg::PIX_W-1:0]         green,
  input  logic [sem_pkg::PIX_W-1:0]         blue,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [sem_pkg::COL_W-1:0]         out_column,
  output logic [sem_pkg::ROW_W-1:0]         out_row,
  output logic [sem_pkg::PIX_W-1:0]         edge_strength,
  output logic                              last_of_run,
  output logic                              frame_done
);

  // front -> queue
  logic              q_push;
  sem_pkg::q_entry_t q_entry;
  logic              q_full;
  // queue -> back
  sem_pkg::q_entry_t q_head;
  logic              q_empty;
  logic              q_pop;

  sem_front #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_front (
    .clk             (clk),
    .rst             (rst),
    .cfg_write_enable(cfg_write_enable),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .red             (red),
    .green           (green),
    .blue            (blue),
    .q_push          (q_push),
    .q_entry         (q_entry),
    .q_full          (q_full)
  );

  sem_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_entry(q_entry),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty)
  );

  sem_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (q_head),
    .q_empty      (q_empty),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_column   (out_column),
    .out_row      (out_row),
    .edge_strength(edge_strength),
    .last_of_run  (last_of_run),
    .frame_done   (frame_done)
  );

endmodule

FILE: hw/rtl/sem_front.sv
// Front end: config registers, raster counters, gray conversion, line stores and 3x3 window.
// Classifies each pixel by the results it releases and pushes it to the queue. Uses sem_pkg.
module sem_front #(
  parameter int MAX_WIDTH = sem_pkg::MAX_WIDTH_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write_enable,
  input  logic [sem_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [sem_pkg::CFG_W-1:0]           cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [sem_pkg::PIX_W-1:0]           red,
  input  logic [sem_pkg::PIX_W-1:0]           green,
  input  logic [sem_pkg::PIX_W-1:0]           blue,
  output logic                                q_push,
  output sem_pkg::q_entry_t                   q_entry,
  input  logic                                q_full
);

  localparam int          AddrW = $clog2(MAX_WIDTH);
  localparam logic [16:0] MaxW  = 17'(MAX_WIDTH);

  logic [sem_pkg::WIDTH_REG_W-1:0]  image_width;
  logic [sem_pkg::HEIGHT_REG_W-1:0] image_height;
  logic [sem_pkg::COL_W-1:0]        column_count;
  logic [sem_pkg::ROW_W-1:0]        row_count;

  logic [sem_pkg::PIX_W-1:0] older_line [MAX_WIDTH];
  logic [sem_pkg::PIX_W-1:0] newer_line [MAX_WIDTH];

  // Stage B: pixel whose line-store read is in flight
  logic                             b_valid;
  logic [sem_pkg::PIX_W-1:0]        b_gray;
  logic [AddrW-1:0]                 b_idx;
  logic [sem_pkg::COL_W-1:0]        b_col;
  logic [sem_pkg::ROW_W-1:0]        b_row;
  sem_pkg::border_t                 b_border;
  logic [sem_pkg::NUM_SLOTS-1:0]    b_slots;

  logic [sem_pkg::PIX_W-1:0] rd_older;
  logic [sem_pkg::PIX_W-1:0] rd_newer;
  logic                      fwd_hit;
  logic [sem_pkg::PIX_W-1:0] fwd_older;
  logic [sem_pkg::PIX_W-1:0] fwd_newer;
  logic [sem_pkg::PIX_W-1:0] older_eff;
  logic [sem_pkg::PIX_W-1:0] newer_eff;

  sem_pkg::window_t window;
  sem_pkg::window_t window_next;

  logic                          in_xfer;
  logic                          b_move;
  logic [16:0]                   w_eff;
  logic [16:0]                   h_eff;
  logic                          last_col;
  logic                          last_row;
  logic [AddrW-1:0]              a_idx;
  sem_pkg::border_t              a_border;
  logic [sem_pkg::NUM_SLOTS-1:0] a_slots;

  // Config
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= sem_pkg::WIDTH_RESET;
      image_height <= sem_pkg::HEIGHT_RESET;
    end else if (cfg_write_enable) begin
      case (cfg_index)
        sem_pkg::REG_IMAGE_WIDTH:  image_width  <= cfg_data[sem_pkg::WIDTH_REG_W-1:0];
        sem_pkg::REG_IMAGE_HEIGHT: image_height <= cfg_data[sem_pkg::HEIGHT_REG_W-1:0];
        default: ;
      endcase
    end
  end

  // Classification of the incoming pixel
  always_comb begin
    if (image_width == '0) begin
      w_eff = 17'd1;
    end else if (17'(image_width) > MaxW) begin
      w_eff = MaxW;
    end else begin
      w_eff = 17'(image_width);
    end
    h_eff    = (image_height == '0) ? 17'd1 : 17'(image_height);
    last_col = (17'(column_count) + 17'd1) >= w_eff;
    last_row = (17'(row_count) + 17'd1) >= h_eff;

    if (32'(column_count) < MAX_WIDTH) begin
      a_idx = AddrW'(column_count);
    end else begin
      a_idx = AddrW'(MAX_WIDTH - 1);
    end

    a_border.col_ge1 = column_count >= 11'd1;
    a_border.col_ge2 = column_count >= 11'd2;
    a_border.row_ge1 = row_count >= 16'd1;
    a_border.row_ge2 = row_count >= 16'd2;

    a_slots                         = '0;
    a_slots[sem_pkg::SLOT_UP_PREV]  = a_border.row_ge1 && a_border.col_ge1;
    a_slots[sem_pkg::SLOT_UP_LAST]  = a_border.row_ge1 && last_col;
    a_slots[sem_pkg::SLOT_CUR_PREV] = last_row && a_border.col_ge1;
    a_slots[sem_pkg::SLOT_CUR_LAST] = last_row && last_col;
  end

  // Stage B leaves when its entry fits in the queue (or releases nothing)
  assign b_move   = b_valid && ((b_slots == '0) || !q_full);
  assign in_stall = b_valid && !b_move;
  assign in_xfer  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (in_xfer) begin
      if (last_col) begin
        column_count <= '0;
        row_count    <= last_row ? '0 : row_count + 16'd1;
      end else begin
        column_count <= column_count + 11'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (in_xfer) begin
      b_valid <= 1'b1;
    end else if (b_move) begin
      b_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      b_gray   <= sem_pkg::gray_of(red, green, blue);
      b_idx    <= a_idx;
      b_col    <= column_count;
      b_row    <= row_count;
      b_border <= a_border;
      b_slots  <= a_slots;
    end
  end

  // Line stores: registered read at accept, read-modify-write when stage B leaves
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      rd_older <= older_line[a_idx];
      rd_newer <= newer_line[a_idx];
    end
    if (b_move) begin
      older_line[b_idx] <= newer_eff;
      newer_line[b_idx] <= b_gray;
    end
  end

  // Same-edge write to the address being read (narrow frames) is forwarded
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_hit <= 1'b0;
    end else if (in_xfer) begin
      fwd_hit <= b_move && (b_idx == a_idx);
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      fwd_older <= newer_eff;
      fwd_newer <= b_gray;
    end
  end

  assign older_eff = fwd_hit ? fwd_older : rd_older;
  assign newer_eff = fwd_hit ? fwd_newer : rd_newer;

  always_comb begin
    window_next = window;
    for (int k = 0; k < 3; k++) begin
      window_next[k*3]     = window[k*3+1];
      window_next[k*3 + 1] = window[k*3+2];
    end
    window_next[2] = older_eff;
    window_next[5] = newer_eff;
    window_next[8] = b_gray;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window <= '0;
    end else if (b_move) begin
      window <= window_next;
    end
  end

  assign q_push         = b_move && (b_slots != '0);
  assign q_entry.window = window_next;
  assign q_entry.col    = b_col;
  assign q_entry.row    = b_row;
  assign q_entry.border = b_border;
  assign q_entry.slots  = b_slots;

endmodule

FILE: hw/rtl/sem_queue.sv
// Short register queue of classified pixels between front and back end.
// Entry type and depth from sem_pkg.
module sem_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  sem_pkg::q_entry_t push_entry,
  output logic              full,
  input  logic              pop,
  output sem_pkg::q_entry_t head,
  output logic              empty
);

  localparam int Depth = sem_pkg::QUEUE_DEPTH;
  localparam int PtrW  = $clog2(Depth);
  localparam int CntW  = $clog2(Depth + 1);

  sem_pkg::q_entry_t entries [Depth];
  logic [PtrW-1:0]   wr_ptr;
  logic [PtrW-1:0]   rd_ptr;
  logic [CntW-1:0]   count;

  assign full  = count == CntW'(Depth);
  assign empty = count == '0;
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PtrW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PtrW'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CntW'(1);
        2'b01:   count <= count - CntW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: hw/rtl/sem_back.sv
// Back end: walks the result slots of the queue head, one Sobel result per cycle when
// not stalled, into the output register. Uses sem_pkg for entry type and sobel_mag.
module sem_back (
  input  logic                          clk,
  input  logic                          rst,
  input  sem_pkg::q_entry_t             head,
  input  logic                          q_empty,
  output logic                          q_pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [sem_pkg::COL_W-1:0]     out_column,
  output logic [sem_pkg::ROW_W-1:0]     out_row,
  output logic [sem_pkg::PIX_W-1:0]     edge_strength,
  output logic                          last_of_run,
  output logic                          frame_done
);

  logic [sem_pkg::NUM_SLOTS-1:0] done_mask;
  logic [sem_pkg::NUM_SLOTS-1:0] pending;
  logic [sem_pkg::NUM_SLOTS-1:0] pick;
  logic [sem_pkg::NUM_SLOTS-1:0] rest;
  logic                          load;
  logic                          emit;
  logic                          is_last_col;
  logic                          is_cur_row;
  logic [1:0]                    ct;
  logic [1:0]                    cm;
  logic [1:0]                    rt;
  logic [1:0]                    rm;

  assign pending = head.slots & ~done_mask;
  assign pick    = pending & (~pending + sem_pkg::NUM_SLOTS'(1));  // lowest pending slot
  assign rest    = pending & ~pick;
  assign load    = !out_valid || !out_stall;
  assign emit    = !q_empty && load;
  assign q_pop   = emit && (rest == '0);

  assign is_last_col = pick[sem_pkg::SLOT_UP_LAST] || pick[sem_pkg::SLOT_CUR_LAST];
  assign is_cur_row  = pick[sem_pkg::SLOT_CUR_PREV] || pick[sem_pkg::SLOT_CUR_LAST];

  // Edge replication: out-of-frame neighbors fall back to the nearest real column/row
  always_comb begin
    if (is_last_col) begin
      ct = head.border.col_ge1 ? sem_pkg::POS_MID : sem_pkg::POS_NEW;
      cm = sem_pkg::POS_NEW;
    end else begin
      ct = head.border.col_ge2 ? sem_pkg::POS_OLD : sem_pkg::POS_MID;
      cm = sem_pkg::POS_MID;
    end
    if (is_cur_row) begin
      rt = head.border.row_ge1 ? sem_pkg::POS_MID : sem_pkg::POS_NEW;
      rm = sem_pkg::POS_NEW;
    end else begin
      rt = head.border.row_ge2 ? sem_pkg::POS_OLD : sem_pkg::POS_MID;
      rm = sem_pkg::POS_MID;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done_mask <= '0;
    end else if (emit) begin
      done_mask <= (rest == '0) ? '0 : (done_mask | pick);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_column    <= is_last_col ? head.col : head.col - 11'd1;
      out_row       <= is_cur_row ? head.row : head.row - 16'd1;
      edge_strength <= sem_pkg::sobel_mag(head.window, ct, cm, sem_pkg::POS_NEW,
                                          rt, rm, sem_pkg::POS_NEW);
      last_of_run   <= rest == '0;
      frame_done    <= pick[sem_pkg::SLOT_CUR_LAST];
    end
  end

endmodule

FILE: hw/rtl/sem_checker.sv
// Port-level checks for sobel_edge_magnitude_core, attached by the bind at the end.
// Depends on sem_pkg for port widths.
module sem_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_stall,
  input logic [sem_pkg::PIX_W-1:0]         red,
  input logic [sem_pkg::PIX_W-1:0]         green,
  input logic [sem_pkg::PIX_W-1:0]         blue,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic [sem_pkg::COL_W-1:0]         out_column,
  input logic [sem_pkg::ROW_W-1:0]         out_row,
  input logic [sem_pkg::PIX_W-1:0]         edge_strength,
  input logic                              last_of_run,
  input logic                              frame_done
);

  // Stalled pixel holds
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid && $stable(red) && $stable(green) && $stable(blue))
    else $error("stalled pixel changed");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_column) && $stable(out_row)
      && $stable(edge_strength) && $stable(last_of_run) && $stable(frame_done))
    else $error("stalled result changed");

  // Frame end is always the final result of its input
  a_frame_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_done |-> last_of_run)
    else $error("frame_done without last_of_run");

  // Results of one input go out back to back
  a_run_cont: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last_of_run |=> out_valid)
    else $error("gap inside a run of results");

  // Reset empties the output register
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind sobel_edge_magnitude_core sem_checker u_sem_checker (.*);
